FILE: rtl/core/fda_pkg.sv
// Shared types, constants and the control store for the fixed-point to ASCII formatter.
// No dependencies; every other file in rtl/core imports this package.
package fda_pkg;

    localparam int FRACTION_BITS = 16;          // fraction bits of the input, 8..24
    localparam int VALUE_W       = 25;
    localparam int INT_W         = 8;           // integer part kept modulo 256
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 4;
    localparam int DIGIT_W       = 4;
    localparam int FRAC_DIGITS   = 4;
    localparam int LOOP_W        = $clog2(FRAC_DIGITS);
    localparam int UC_DEPTH      = 7;
    localparam int STEP_W        = $clog2(UC_DEPTH);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [LOOP_W-1:0] LOOP_LAST = LOOP_W'(FRAC_DIGITS - 1);

    // character source of a step
    typedef enum logic [2:0] {
        SRC_MINUS,
        SRC_HUND,
        SRC_TENS,
        SRC_ONES,
        SRC_DOT,
        SRC_FRAC,
        SRC_NUL
    } t_src;

    // emit condition; when false the step is skipped without output
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_NEG,
        C_HUND,
        C_TENS
    } t_cond;

    typedef enum logic [1:0] {
        J_NEXT,
        J_LOOP,
        J_END
    } t_jmp;

    typedef struct packed {
        t_src  src;
        t_cond cond;
        t_jmp  jmp;
        logic  last;
    } t_uop;

    // sequencer -> datapath
    typedef struct packed {
        logic load;
        logic emit;
        t_src src;
        logic last;
    } t_dp_ctrl;

    // datapath -> sequencer
    typedef struct packed {
        logic neg;
        logic hund_nz;
        logic tens_nz;
        logic out_free;
    } t_dp_stat;

    localparam t_uop UCODE [UC_DEPTH] = '{
        '{src: SRC_MINUS, cond: C_NEG,    jmp: J_NEXT, last: 1'b0},
        '{src: SRC_HUND,  cond: C_HUND,   jmp: J_NEXT, last: 1'b0},
        '{src: SRC_TENS,  cond: C_TENS,   jmp: J_NEXT, last: 1'b0},
        '{src: SRC_ONES,  cond: C_ALWAYS, jmp: J_NEXT, last: 1'b0},
        '{src: SRC_DOT,   cond: C_ALWAYS, jmp: J_NEXT, last: 1'b0},
        '{src: SRC_FRAC,  cond: C_ALWAYS, jmp: J_LOOP, last: 1'b0},
        '{src: SRC_NUL,   cond: C_ALWAYS, jmp: J_END,  last: 1'b1}
    };

endpackage

FILE: rtl/core/fda_in_if.sv
// Input channel of the formatter: valid/ready handshake carrying one fixed-point value.
// Depends on fda_pkg for the value width.
interface fda_in_if import fda_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

FILE: rtl/core/fda_out_if.sv
// Output channel of the formatter: one ASCII character per item, with end marker and length.
// Depends on fda_pkg for the field widths.
interface fda_out_if import fda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output character, output is_last, output length, input ready);
    modport sink (input valid, input character, input is_last, input length, output ready);
endinterface

FILE: rtl/core/fda_seq.sv
// Microcode sequencer: step counter, fraction loop counter and conditional jumps over UCODE.
// Depends on fda_pkg (control store, control and status structs).
module fda_seq import fda_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    logic [LOOP_W-1:0] r_loop, n_loop;

    t_uop uop;
    logic cond_ok;
    logic advance;
    logic load;

    assign uop = UCODE[r_step];

    always_comb begin
        case (uop.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_NEG:    cond_ok = i_stat.neg;
            C_HUND:   cond_ok = i_stat.hund_nz;
            C_TENS:   cond_ok = i_stat.tens_nz;
            default:  cond_ok = 1'b1;
        endcase
    end

    assign load    = i_in_valid && !r_busy;
    // a skipped step moves on at once; an emitting step waits for the output slot
    assign advance = r_busy && (!cond_ok || i_stat.out_free);

    assign o_in_ready  = !r_busy;
    assign o_ctrl.load = load;
    assign o_ctrl.emit = r_busy && cond_ok && i_stat.out_free;
    assign o_ctrl.src  = uop.src;
    assign o_ctrl.last = uop.last;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_loop = r_loop;
        if (load) begin
            n_busy = 1'b1;
            n_step = '0;
            n_loop = '0;
        end else if (advance) begin
            case (uop.jmp)
                J_LOOP: begin
                    if (r_loop != LOOP_LAST) begin
                        n_loop = r_loop + 1'b1;
                    end else begin
                        n_loop = '0;
                        n_step = r_step + 1'b1;
                    end
                end
                J_END: begin
                    n_busy = 1'b0;
                    n_step = '0;
                end
                default: n_step = r_step + 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_loop <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_loop <= n_loop;
        end
    end

endmodule

FILE: rtl/core/fda_dpath.sv
// Datapath: operand registers, integer digit split, fraction digit generator, output register.
// Depends on fda_pkg; driven by fda_seq through t_dp_ctrl.
module fda_dpath import fda_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_dp_ctrl                  i_ctrl,
    output t_dp_stat                  o_stat,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [CHAR_W-1:0]         o_character,
    output logic                      o_is_last,
    output logic [LEN_W-1:0]          o_length
);

    logic                     r_neg;
    logic [INT_W-1:0]         r_ipart;
    logic [FRACTION_BITS-1:0] r_frac;
    logic [LEN_W-1:0]         r_len;
    logic                     r_o_valid;
    logic [CHAR_W-1:0]        r_o_char;
    logic                     r_o_last;
    logic [LEN_W-1:0]         r_o_len;

    logic [VALUE_W-1:0]         v_bits;
    logic [VALUE_W-1:0]         mag;
    logic [1:0]                 hund;
    logic [6:0]                 rem;
    logic [14:0]                rem_x;
    logic [DIGIT_W-1:0]         tens;
    logic [DIGIT_W-1:0]         ones;
    logic [FRACTION_BITS+3:0]   prod;
    logic [DIGIT_W-1:0]         digit;
    logic [CHAR_W-1:0]          ch;

    assign v_bits = i_value;
    assign mag    = v_bits[VALUE_W-1] ? (~v_bits + 1'b1) : v_bits;

    // integer part split into three digits: compare for hundreds, reciprocal for tens
    always_comb begin
        if (r_ipart >= INT_W'(200)) begin
            hund = 2'd2;
            rem  = 7'(r_ipart - INT_W'(200));
        end else if (r_ipart >= INT_W'(100)) begin
            hund = 2'd1;
            rem  = 7'(r_ipart - INT_W'(100));
        end else begin
            hund = 2'd0;
            rem  = 7'(r_ipart);
        end
    end

    // rem * 205 >> 11 equals rem / 10 for rem below 100
    assign rem_x = {8'b0, rem} * 15'd205;
    assign tens  = DIGIT_W'(rem_x >> 11);
    assign ones  = DIGIT_W'(rem - (7'(tens) * 7'd10));

    // fraction digit: next decimal digit falls out above the binary point of frac * 10
    assign prod  = {1'b0, r_frac, 3'b0} + {3'b0, r_frac, 1'b0};
    assign digit = prod[FRACTION_BITS +: DIGIT_W];

    always_comb begin
        case (i_ctrl.src)
            SRC_MINUS: ch = CH_MINUS;
            SRC_HUND:  ch = CH_ZERO + CHAR_W'(hund);
            SRC_TENS:  ch = CH_ZERO + CHAR_W'(tens);
            SRC_ONES:  ch = CH_ZERO + CHAR_W'(ones);
            SRC_DOT:   ch = CH_DOT;
            SRC_FRAC:  ch = CH_ZERO + CHAR_W'(digit);
            SRC_NUL:   ch = CH_NUL;
            default:   ch = CH_NUL;
        endcase
    end

    assign o_stat.neg      = r_neg;
    assign o_stat.hund_nz  = hund != 2'd0;
    assign o_stat.tens_nz  = (hund != 2'd0) || (tens != '0);
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_neg   <= v_bits[VALUE_W-1];
            r_ipart <= INT_W'(mag >> FRACTION_BITS);
            r_frac  <= mag[FRACTION_BITS-1:0];
            r_len   <= '0;
        end else if (i_ctrl.emit) begin
            if (i_ctrl.src != SRC_MINUS) begin
                r_len <= r_len + 1'b1;
            end
            if (i_ctrl.src == SRC_FRAC) begin
                r_frac <= prod[FRACTION_BITS-1:0];
            end
        end
        if (i_ctrl.emit) begin
            r_o_char <= ch;
            r_o_last <= i_ctrl.last;
            r_o_len  <= i_ctrl.last ? LEN_W'(r_len + 1'b1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_character = r_o_char;
    assign o_is_last   = r_o_last;
    assign o_length    = r_o_len;

endmodule

FILE: rtl/core/fixed_to_decimal_ascii_core.sv
// Top level of the fixed-point to decimal ASCII formatter: sequencer plus datapath.
// Depends on fda_pkg, fda_in_if, fda_out_if, fda_seq and fda_dpath.
//
//  channel     dir  fields                          item
//  i_value_ch  in   value[24:0] signed Q8.16        one number to format
//  o_char_ch   out  character[7:0] is_last length   one ASCII character, NUL last
//
// One value is accepted, then runs through ten sequencer steps (seven control words, the
// fraction word looping four times); each emitting step waits for a free output register.
// Sign and leading-zero steps are skipped without output.
// A stalled output register holds the step counter; the next value is taken once the
// NUL has been written to the output register. Reset clears the sequencer and valid flag.
module fixed_to_decimal_ascii_core import fda_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fda_in_if.sink    i_value_ch,
    fda_out_if.source o_char_ch
);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    fda_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value_ch.valid),
        .o_in_ready (i_value_ch.ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    fda_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value_ch.value),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_out_ready (o_char_ch.ready),
        .o_out_valid (o_char_ch.valid),
        .o_character (o_char_ch.character),
        .o_is_last   (o_char_ch.is_last),
        .o_length    (o_char_ch.length)
    );

endmodule

FILE: rtl/core/fda_checker.sv
// Port-level checks for the formatter, bound to the top level.
// Depends on fda_pkg for field widths and the NUL code.
module fda_checker import fda_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] i_character,
    input logic              i_is_last,
    input logic [LEN_W-1:0]  i_length
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_character) && $stable(i_is_last) && $stable(i_length))
        else $error("output item changed under stall");

    // one value at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while formatting");

    a_len_zero_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_last |-> i_length == '0 && i_character != CH_NUL)
        else $error("length or NUL on non-final item");

    a_last_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_last |->
            i_character == CH_NUL && i_length >= LEN_W'(7) && i_length <= LEN_W'(9))
        else $error("bad final item");

endmodule

bind fixed_to_decimal_ascii_core fda_checker u_fda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_value_ch.valid),
    .i_in_ready  (i_value_ch.ready),
    .i_out_valid (o_char_ch.valid),
    .i_out_ready (o_char_ch.ready),
    .i_character (o_char_ch.character),
    .i_is_last   (o_char_ch.is_last),
    .i_length    (o_char_ch.length)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for fixed_to_decimal_ascii_core: drives signed fixed-point values, predicts
// the ASCII text of each and checks every character item that comes back, in order.
// Depends on fda_pkg, fda_in_if, fda_out_if and the RTL under rtl/core.
module tb_top;
    import fda_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              is_last;
        logic [LEN_W-1:0]  length;
    } t_char_item;

    logic i_clk;
    logic i_rst_n;

    fda_in_if  value_ch ();
    fda_out_if char_ch ();

    fixed_to_decimal_ascii_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value_ch (value_ch),
        .o_char_ch  (char_ch)
    );

    logic [VALUE_W-1:0] pending_values [$];
    t_char_item         expected_chars [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    logic hold_start   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void queue_char(logic [CHAR_W-1:0] ch, logic last, int len);
        t_char_item item;
        item.character = ch;
        item.is_last   = last;
        item.length    = LEN_W'(len);
        expected_chars.push_back(item);
    endfunction

    // Expected text of one value: sign, integer digits without leading zeros,
    // point, four truncated fraction digits, NUL carrying the unsigned length
    function automatic void format_value_text(logic [VALUE_W-1:0] value);
        longint unsigned magnitude;
        longint unsigned int_part;
        longint unsigned frac;
        longint unsigned scale;
        int text_len;
        magnitude = value[VALUE_W-1] ? ((64'd1 << VALUE_W) - 64'(value)) : 64'(value);
        int_part  = (magnitude >> FRACTION_BITS) & 64'hFF;
        frac      = magnitude & ((64'd1 << FRACTION_BITS) - 1);
        text_len  = 0;
        if (value[VALUE_W-1]) begin
            queue_char(CH_MINUS, 1'b0, 0);
        end
        if (int_part >= 100) begin
            queue_char(CH_ZERO + CHAR_W'(int_part / 100), 1'b0, 0);
            text_len++;
        end
        if (int_part >= 10) begin
            queue_char(CH_ZERO + CHAR_W'((int_part / 10) % 10), 1'b0, 0);
            text_len++;
        end
        queue_char(CH_ZERO + CHAR_W'(int_part % 10), 1'b0, 0);
        queue_char(CH_DOT, 1'b0, 0);
        text_len += 2;
        scale = 1;
        for (int k = 0; k < FRAC_DIGITS; k++) begin
            scale = scale * 10;
            queue_char(CH_ZERO + CHAR_W'(((frac * scale) >> FRACTION_BITS) % 10), 1'b0, 0);
            text_len++;
        end
        text_len++;
        queue_char(CH_NUL, 1'b1, text_len);
    endfunction

    // Mostly well-formed magnitudes of each digit count, plus raw bit patterns
    function automatic logic [VALUE_W-1:0] random_fixed_value();
        longint unsigned int_part;
        longint unsigned frac;
        longint unsigned magnitude;
        logic            negative;
        int              pick;
        pick     = int'($urandom_range(0, 9));
        negative = 1'($urandom_range(0, 1));
        frac     = 64'($urandom_range(0, (1 << FRACTION_BITS) - 1));
        case (pick)
            0, 1, 2: begin
                return VALUE_W'($urandom());
            end
            3: int_part = 64'($urandom_range(0, 9));
            4: int_part = 64'($urandom_range(10, 99));
            5, 6: int_part = 64'($urandom_range(100, 255));
            7: begin
                int_part = 0;
                frac     = 64'($urandom_range(0, 15));
            end
            default: begin
                int_part = 64'($urandom_range(0, 255));
                case ($urandom_range(0, 2))
                    0: frac = 0;
                    1: frac = 64'((1 << FRACTION_BITS) - 1);
                    default: frac = 1;
                endcase
            end
        endcase
        magnitude = (int_part << FRACTION_BITS) | frac;
        return negative ? VALUE_W'(-magnitude) : VALUE_W'(magnitude);
    endfunction

    task automatic queue_random_values(int count);
        repeat (count) pending_values.push_back(random_fixed_value());
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        while (pending_values.size() != 0 || value_ch.valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            value_ch.valid <= 1'b0;
        end else if (!value_ch.valid || value_ch.ready) begin
            if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                value_ch.valid <= 1'b1;
                value_ch.value <= pending_values.pop_front();
            end else begin
                value_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: check outputs first, then predict from the input item taken on this edge
    always @(posedge i_clk) begin : char_monitor
        t_char_item got;
        t_char_item want;
        if (!i_rst_n) begin
            char_ch.ready <= 1'b0;
        end else begin
            if (char_ch.valid && char_ch.ready) begin
                got.character = char_ch.character;
                got.is_last   = char_ch.is_last;
                got.length    = char_ch.length;
                if (expected_chars.size() == 0) begin
                    log_mismatch($sformatf("unexpected char item: char %h last %b len %0d",
                        got.character, got.is_last, got.length));
                end else begin
                    want = expected_chars.pop_front();
                    if (got.character !== want.character || got.is_last !== want.is_last
                        || got.length !== want.length) begin
                        log_mismatch($sformatf(
                            "char mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                            want.character, want.is_last, want.length,
                            got.character, got.is_last, got.length));
                    end
                end
            end
            if (value_ch.valid && value_ch.ready) begin
                format_value_text(value_ch.value);
            end
            char_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [VALUE_W-1:0] directed [$];
        i_rst_n        = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        char_ch.ready  = 1'b0;
        directed = '{
            25'h0000000, 25'h0000001, 25'h000FFFF, 25'h0008000,
            25'h000199A, 25'h0001999, 25'h0010000, 25'h009FFFF,
            25'h00A0000, 25'h063FFFF, 25'h0640000, 25'h07B8000,
            25'h0FF0000, 25'h0FF0001, 25'h0FFFFFF,
            25'h1FFFFFF,                    // tiny negative still signed
            25'h1000000,                    // most negative pattern
            25'h1000001,
            -25'h0648000, -25'h00A1999, -25'h063FFFF, -25'h0000100,
            -25'h0010000
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        foreach (directed[i]) pending_values.push_back(directed[i]);
        queue_random_values(100);
        wait_until_drained();

        send_idle_pct = 81;
        queue_random_values(100);
        wait_until_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 81;
        queue_random_values(100);
        wait_until_drained();

        send_idle_pct  = 11;
        recv_stall_pct = 11;
        queue_random_values(90);
        wait_until_drained();

        // receiver held off while the sender keeps offering: block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_values(30);
        hold_start = 1'b1;
        @(negedge i_clk);
        hold_start = 1'b0;
        wait_until_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/fda_pkg.sv
rtl/core/fda_in_if.sv
rtl/core/fda_out_if.sv
rtl/core/fda_seq.sv
rtl/core/fda_dpath.sv
rtl/core/fixed_to_decimal_ascii_core.sv
rtl/core/fda_checker.sv
tb/tb_top.sv
